// ===== rtl/core/slse_pkg.sv =====
// ----------------------------------------------------------------------------
// slse_pkg - status lamp effect sequencer package
// Shared codes, widths, reset values and interface structs.
// ----------------------------------------------------------------------------
package slse_pkg;

   // elapsed counter width
   localparam int COUNTER_BITS = 16;

   // opcodes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_MODE = 1'b1;

   // mode codes
   localparam logic [3:0] MODE_IDLE     = 4'd0;
   localparam logic [3:0] MODE_THINKING = 4'd1;
   localparam logic [3:0] MODE_AI       = 4'd2;
   localparam logic [3:0] MODE_BUSY     = 4'd3;
   localparam logic [3:0] MODE_SUCCESS  = 4'd4;
   localparam logic [3:0] MODE_WAIT_LO  = 4'd5;
   localparam logic [3:0] MODE_WAIT_HI  = 4'd8;
   localparam logic [3:0] MODE_ERROR    = 4'd9;
   localparam logic [3:0] MODE_OFF      = 4'd10;

   // frame intervals in ticks
   localparam int IV_BREATH = 14;
   localparam int IV_THINK  = 110;
   localparam int IV_AI     = 240;
   localparam int IV_BUSY   = 550;
   localparam int IV_ERROR  = 130;

   // configuration register indexes
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACTIVE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FULL_LEVEL   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SOFT_LEVEL   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRAIL_LEVEL  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BREATH_FLOOR = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SUCCESS_HOLD = 3'd5;

   // configuration reset values
   localparam logic [7:0]  FULL_LEVEL_RST   = 8'd140;
   localparam logic [7:0]  SOFT_LEVEL_RST   = 8'd84;
   localparam logic [7:0]  TRAIL_LEVEL_RST  = 8'd28;
   localparam logic [7:0]  BREATH_FLOOR_RST = 8'd6;
   localparam logic [15:0] SUCCESS_HOLD_RST = 16'd5000;

   typedef struct packed {
      logic        active_high;
      logic [7:0]  full_level;
      logic [7:0]  soft_level;
      logic [7:0]  trail_level;
      logic [7:0]  breath_floor;
      logic [15:0] hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] yellow;
      logic [7:0] green;
   } lamp_type;

endpackage

// ===== rtl/core/slse_csr.sv =====
// ----------------------------------------------------------------------------
// slse_csr - configuration registers
// Holds the six effect settings written through the plain write port.
// ----------------------------------------------------------------------------
module slse_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [slse_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [slse_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output slse_pkg::cfg_type                  cfg
);
   import slse_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode one write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ACTIVE_HIGH:  cfg_in.active_high     = csr_wdata[0];
            CSR_FULL_LEVEL:   cfg_in.full_level      = csr_wdata[7:0];
            CSR_SOFT_LEVEL:   cfg_in.soft_level      = csr_wdata[7:0];
            CSR_TRAIL_LEVEL:  cfg_in.trail_level     = csr_wdata[7:0];
            CSR_BREATH_FLOOR: cfg_in.breath_floor    = csr_wdata[7:0];
            CSR_SUCCESS_HOLD: cfg_in.hold_ticks      = csr_wdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_high     <= 1'b0;
         cfg_ff.full_level      <= FULL_LEVEL_RST;
         cfg_ff.soft_level      <= SOFT_LEVEL_RST;
         cfg_ff.trail_level     <= TRAIL_LEVEL_RST;
         cfg_ff.breath_floor    <= BREATH_FLOOR_RST;
         cfg_ff.hold_ticks      <= SUCCESS_HOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/slse_engine.sv =====
// ----------------------------------------------------------------------------
// slse_engine - effect state and next-state logic
// Mode, frame and mode counters, chase, blink and breathing state.
// Gives the next lamp levels and mode for the beat being taken.
// ----------------------------------------------------------------------------
module slse_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                opcode,
   input  logic [3:0]          mode_code,
   input  slse_pkg::cfg_type   cfg,
   output slse_pkg::lamp_type  levels_next,
   output logic [3:0]          mode_next
);
   import slse_pkg::*;

   localparam int CMP_BITS = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
   localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

   logic [3:0]              mode_ff, mode_in;
   logic [COUNTER_BITS-1:0] frame_ff, frame_in;
   logic [COUNTER_BITS-1:0] elapsed_ff, elapsed_in;
   logic                    first_ff, first_in;
   logic [2:0]              chase_ff, chase_in;
   logic                    lit_ff, lit_in;
   logic [7:0]              breath_ff, breath_in;
   logic                    rising_ff, rising_in;
   lamp_type                levels_ff, levels_in;

   logic [COUNTER_BITS-1:0] frame_inc, elapsed_inc;
   logic [COUNTER_BITS-1:0] interval;
   logic                    due;
   logic signed [9:0]       breath_step;
   logic                    enter_en;
   logic [3:0]              enter_code;

   // full-level chase frames
   function automatic lamp_type think_frame(input logic [2:0] pos, input logic [7:0] f);
      lamp_type l;
      case (pos)
         3'd0:    l = '{red: f,    yellow: 8'd0, green: 8'd0};
         3'd1:    l = '{red: f,    yellow: f,    green: 8'd0};
         3'd2:    l = '{red: 8'd0, yellow: f,    green: 8'd0};
         3'd3:    l = '{red: 8'd0, yellow: f,    green: f};
         3'd4:    l = '{red: 8'd0, yellow: 8'd0, green: f};
         default: l = '{red: f,    yellow: 8'd0, green: f};
      endcase
      return l;
   endfunction

   // soft chase frames with a dim trail
   function automatic lamp_type ai_frame(input logic [2:0] pos, input logic [7:0] s,
                                         input logic [7:0] t);
      lamp_type l;
      case (pos)
         3'd0:    l = '{red: s,    yellow: t,    green: 8'd0};
         3'd1:    l = '{red: t,    yellow: s,    green: 8'd0};
         3'd2:    l = '{red: 8'd0, yellow: s,    green: t};
         3'd3:    l = '{red: 8'd0, yellow: t,    green: s};
         3'd4:    l = '{red: t,    yellow: 8'd0, green: s};
         default: l = '{red: s,    yellow: 8'd0, green: t};
      endcase
      return l;
   endfunction

   // saturating counters
   assign frame_inc   = (frame_ff == CNT_MAX) ? frame_ff : frame_ff + 1'b1;
   assign elapsed_inc = (elapsed_ff == CNT_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   // frame interval of the current mode
   always_comb begin
      case (mode_ff)
         MODE_IDLE:     interval = COUNTER_BITS'(IV_BREATH);
         MODE_THINKING: interval = COUNTER_BITS'(IV_THINK);
         MODE_AI:       interval = COUNTER_BITS'(IV_AI);
         MODE_BUSY:     interval = COUNTER_BITS'(IV_BUSY);
         MODE_ERROR:    interval = COUNTER_BITS'(IV_ERROR);
         default:       interval = CNT_MAX;
      endcase
   end

   assign due = first_ff || (frame_inc >= interval);

   // breathing step, signed so it may dip below zero
   assign breath_step = rising_ff ? ($signed({2'b00, breath_ff}) + 10'sd2)
                                  : ($signed({2'b00, breath_ff}) - 10'sd2);

   // next state
   always_comb begin
      mode_in    = mode_ff;
      frame_in   = frame_ff;
      elapsed_in = elapsed_ff;
      first_in   = first_ff;
      chase_in   = chase_ff;
      lit_in     = lit_ff;
      breath_in  = breath_ff;
      rising_in  = rising_ff;
      levels_in  = levels_ff;
      enter_en   = 1'b0;
      enter_code = mode_code;

      if (step) begin
         if (opcode == OP_TICK) begin
            frame_in   = frame_inc;
            elapsed_in = elapsed_inc;
            case (mode_ff)
               MODE_IDLE: begin
                  if (due) begin
                     first_in = 1'b0;
                     frame_in = '0;
                     if (breath_step >= $signed({2'b00, cfg.full_level})) begin
                        breath_in = cfg.full_level;
                        rising_in = 1'b0;
                     end else if (breath_step <= $signed({2'b00, cfg.breath_floor})) begin
                        breath_in = cfg.breath_floor;
                        rising_in = 1'b1;
                     end else begin
                        breath_in = breath_step[7:0];
                     end
                     levels_in = '{red: 8'd0, yellow: 8'd0, green: breath_in};
                  end
               end
               MODE_THINKING, MODE_AI: begin
                  if (due) begin
                     first_in  = 1'b0;
                     frame_in  = '0;
                     levels_in = (mode_ff == MODE_THINKING)
                                 ? think_frame(chase_ff, cfg.full_level)
                                 : ai_frame(chase_ff, cfg.soft_level, cfg.trail_level);
                     chase_in  = (chase_ff >= 3'd5) ? 3'd0 : chase_ff + 3'd1;
                  end
               end
               MODE_BUSY: begin
                  if (due) begin
                     first_in  = 1'b0;
                     frame_in  = '0;
                     lit_in    = !lit_ff;
                     levels_in = '{red: 8'd0, yellow: lit_in ? cfg.soft_level : 8'd0,
                                   green: 8'd0};
                  end
               end
               MODE_ERROR: begin
                  if (due) begin
                     first_in  = 1'b0;
                     frame_in  = '0;
                     lit_in    = !lit_ff;
                     levels_in = '{red: lit_in ? cfg.full_level : 8'd0, yellow: 8'd0,
                                   green: 8'd0};
                  end
               end
               MODE_SUCCESS: begin
                  levels_in = '{red: 8'd0, yellow: 8'd0, green: cfg.full_level};
                  if (CMP_BITS'(elapsed_inc) >= CMP_BITS'(cfg.hold_ticks)) begin
                     enter_en   = 1'b1;
                     enter_code = MODE_IDLE;
                  end
               end
               MODE_OFF: begin
                  levels_in = '0;
               end
               default: begin
                  if (mode_ff >= MODE_WAIT_LO && mode_ff <= MODE_WAIT_HI) begin
                     levels_in = '{red: 8'd0, yellow: cfg.full_level, green: 8'd0};
                  end
               end
            endcase
         end else if (mode_code <= MODE_OFF) begin
            enter_en = 1'b1;
         end
      end

      // mode entry clears the effect state
      if (enter_en) begin
         mode_in    = enter_code;
         elapsed_in = '0;
         frame_in   = '0;
         first_in   = 1'b1;
         chase_in   = 3'd0;
         lit_in     = 1'b0;
         breath_in  = cfg.breath_floor;
         rising_in  = 1'b1;
         levels_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OFF;
         frame_ff   <= '0;
         elapsed_ff <= '0;
         first_ff   <= 1'b1;
         chase_ff   <= 3'd0;
         lit_ff     <= 1'b0;
         breath_ff  <= BREATH_FLOOR_RST;
         rising_ff  <= 1'b1;
         levels_ff  <= '0;
      end else begin
         mode_ff    <= mode_in;
         frame_ff   <= frame_in;
         elapsed_ff <= elapsed_in;
         first_ff   <= first_in;
         chase_ff   <= chase_in;
         lit_ff     <= lit_in;
         breath_ff  <= breath_in;
         rising_ff  <= rising_in;
         levels_ff  <= levels_in;
      end
   end

   assign levels_next = levels_in;
   assign mode_next   = mode_in;

`ifndef SYNTHESIS
   // chase never leaves its six frames
   a_chase_range: assert property (@(posedge clock) disable iff (reset)
      chase_ff <= 3'd5)
      else $error("chase position out of range");

   // off mode keeps every lamp dark
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_OFF) |-> (levels_ff == '0))
      else $error("lamp lit in off mode");

   // a valid mode command lands and blanks the lamps
   a_mode_enter: assert property (@(posedge clock) disable iff (reset)
      (step && opcode == OP_MODE && mode_code <= MODE_OFF) |=>
      (mode_ff == $past(mode_code) && levels_ff == '0 && first_ff && elapsed_ff == '0))
      else $error("mode command not applied");

   // a frame that was due restarts the frame counter
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (step && opcode == OP_TICK && due && mode_ff != MODE_SUCCESS && mode_ff != MODE_OFF
       && !(mode_ff >= MODE_WAIT_LO && mode_ff <= MODE_WAIT_HI)) |=>
      (frame_ff == '0 && !first_ff))
      else $error("frame counter not restarted");
`endif

endmodule

// ===== rtl/core/slse_out.sv =====
// ----------------------------------------------------------------------------
// slse_out - duty shaping and result register
// Clamps each lamp level to the full level, applies lamp polarity and
// holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module slse_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  slse_pkg::lamp_type levels,
   input  logic [3:0]         mode,
   input  slse_pkg::cfg_type  cfg,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [7:0]         rsp_red_duty,
   output logic [7:0]         rsp_yellow_duty,
   output logic [7:0]         rsp_green_duty,
   output logic [3:0]         rsp_mode_now
);
   import slse_pkg::*;

   logic       valid_ff, valid_in;
   lamp_type   duty_ff, duty_in;
   logic [3:0] mode_ff;

   // clamp, then invert for active-low lamps
   function automatic logic [7:0] shape(input logic [7:0] lv, input cfg_type c);
      logic [7:0] l;
      l = (lv > c.full_level) ? c.full_level : lv;
      return c.active_high ? l : ~l;
   endfunction

   always_comb begin
      duty_in.red    = shape(levels.red, cfg);
      duty_in.yellow = shape(levels.yellow, cfg);
      duty_in.green  = shape(levels.green, cfg);
      valid_in       = load || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         duty_ff <= duty_in;
         mode_ff <= mode;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_red_duty    = duty_ff.red;
   assign rsp_yellow_duty = duty_ff.yellow;
   assign rsp_green_duty  = duty_ff.green;
   assign rsp_mode_now    = mode_ff;

endmodule

// ===== rtl/core/status_light_effect_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// status_light_effect_sequencer_unit - three-lamp status effect sequencer
// Runs breathing, chase, blink and hold effects from tick and mode beats.
//
//   channel | ports                          | direction | beat
//   --------+--------------------------------+-----------+--------------------
//   req     | req_valid/ready, opcode, code  | in        | tick or mode command
//   rsp     | rsp_valid/ready, duties, mode  | out       | one per req beat
//   csr     | csr_wr_en, csr_index, wdata    | in        | register write
//
// One req beat per cycle while req_ready is high; its rsp beat shows in the
// next cycle from the result register. Effect state updates as the beat is taken.
// req_ready is low only while a result is held and rsp_ready is low.
// Reset is synchronous and returns mode off, dark lamps and default settings.
// ----------------------------------------------------------------------------
module status_light_effect_sequencer_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [3:0]                         req_mode_code,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_red_duty,
   output logic [7:0]                         rsp_yellow_duty,
   output logic [7:0]                         rsp_green_duty,
   output logic [3:0]                         rsp_mode_now,
   input  logic                               csr_wr_en,
   input  logic [slse_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [slse_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import slse_pkg::*;

   cfg_type    cfg;
   lamp_type   levels_next;
   logic [3:0] mode_next;
   logic       step;

   // take a beat whenever the result slot frees up this cycle
   assign req_ready = !rsp_valid || rsp_ready;
   assign step      = req_valid && req_ready;

   slse_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slse_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .opcode      (req_opcode),
      .mode_code   (req_mode_code),
      .cfg         (cfg),
      .levels_next (levels_next),
      .mode_next   (mode_next)
   );

   slse_out u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (step),
      .levels          (levels_next),
      .mode            (mode_next),
      .cfg             (cfg),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_red_duty    (rsp_red_duty),
      .rsp_yellow_duty (rsp_yellow_duty),
      .rsp_green_duty  (rsp_green_duty),
      .rsp_mode_now    (rsp_mode_now)
   );

endmodule

// ===== bench/slse_checker.sv =====
// ----------------------------------------------------------------------------
// slse_checker - scoreboard for the status lamp effect sequencer
// Watches the req, rsp and csr ports. It keeps its own copy of the settings
// and effect state, predicts the duties and mode for each accepted req beat,
// and compares every rsp beat against the oldest prediction.
// ----------------------------------------------------------------------------
module slse_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [3:0]                         req_mode_code,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [7:0]                         rsp_red_duty,
   input  logic [7:0]                         rsp_yellow_duty,
   input  logic [7:0]                         rsp_green_duty,
   input  logic [3:0]                         rsp_mode_now,
   input  logic                               csr_wr_en,
   input  logic [slse_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [slse_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                 fail_count,
   output int                                 pending_count
);
   import slse_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] yellow;
      logic [7:0] green;
      logic [3:0] mode;
   } lamp_beat_type;

   localparam logic [COUNTER_BITS-1:0] AGE_MAX = '1;

   // shadow settings and effect state
   cfg_type                 cfg;
   logic [3:0]              cur_mode;
   logic [COUNTER_BITS-1:0] frame_age;
   logic [COUNTER_BITS-1:0] mode_age;
   logic                    frame_armed;
   logic [2:0]              chase_step;
   logic                    blink_on;
   logic [7:0]              glow;
   logic                    glow_up;
   lamp_type                lamp;

   // predicted rsp beats, oldest first
   lamp_beat_type           due_lamps[$];
   int                      mismatches = 0;
   int                      queued = 0;

   assign fail_count    = mismatches;
   assign pending_count = queued;

   // mode entry: clears effect state and blanks the lamps
   function automatic void start_effect(input logic [3:0] m);
      cur_mode    = m;
      mode_age    = '0;
      frame_age   = '0;
      frame_armed = 1'b1;
      chase_step  = '0;
      blink_on    = 1'b0;
      glow        = cfg.breath_floor;
      glow_up     = 1'b1;
      lamp        = '0;
   endfunction

   function automatic bit frame_hit(input int interval);
      if (frame_armed || frame_age >= interval) begin
         frame_armed = 1'b0;
         frame_age   = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void next_chase();
      chase_step = (chase_step >= 3'd5) ? 3'd0 : chase_step + 3'd1;
   endfunction

   // one millisecond of effect time
   function automatic void tick_effects();
      int         lv;
      logic [7:0] f;
      logic [7:0] s;
      logic [7:0] t;
      f = cfg.full_level;
      s = cfg.soft_level;
      t = cfg.trail_level;
      if (frame_age != AGE_MAX) frame_age++;
      if (mode_age != AGE_MAX) mode_age++;
      case (cur_mode)
         MODE_IDLE: begin
            if (frame_hit(IV_BREATH)) begin
               lv = int'(glow) + (glow_up ? 2 : -2);
               if (lv >= int'(cfg.full_level)) begin
                  lv      = int'(cfg.full_level);
                  glow_up = 1'b0;
               end else if (lv <= int'(cfg.breath_floor)) begin
                  lv      = int'(cfg.breath_floor);
                  glow_up = 1'b1;
               end
               glow = lv[7:0];
               lamp = {8'd0, 8'd0, glow};
            end
         end
         MODE_THINKING: begin
            if (frame_hit(IV_THINK)) begin
               case (chase_step)
                  3'd0:    lamp = {f, 8'd0, 8'd0};
                  3'd1:    lamp = {f, f, 8'd0};
                  3'd2:    lamp = {8'd0, f, 8'd0};
                  3'd3:    lamp = {8'd0, f, f};
                  3'd4:    lamp = {8'd0, 8'd0, f};
                  default: lamp = {f, 8'd0, f};
               endcase
               next_chase();
            end
         end
         MODE_AI: begin
            if (frame_hit(IV_AI)) begin
               case (chase_step)
                  3'd0:    lamp = {s, t, 8'd0};
                  3'd1:    lamp = {t, s, 8'd0};
                  3'd2:    lamp = {8'd0, s, t};
                  3'd3:    lamp = {8'd0, t, s};
                  3'd4:    lamp = {t, 8'd0, s};
                  default: lamp = {s, 8'd0, t};
               endcase
               next_chase();
            end
         end
         MODE_BUSY: begin
            if (frame_hit(IV_BUSY)) begin
               blink_on = !blink_on;
               lamp     = {8'd0, blink_on ? s : 8'd0, 8'd0};
            end
         end
         MODE_SUCCESS: begin
            lamp = {8'd0, 8'd0, f};
            if (mode_age >= cfg.hold_ticks) start_effect(MODE_IDLE);
         end
         MODE_ERROR: begin
            if (frame_hit(IV_ERROR)) begin
               blink_on = !blink_on;
               lamp     = {blink_on ? f : 8'd0, 8'd0, 8'd0};
            end
         end
         MODE_OFF: lamp = '0;
         default: begin
            if (cur_mode >= MODE_WAIT_LO && cur_mode <= MODE_WAIT_HI) lamp = {8'd0, f, 8'd0};
         end
      endcase
   endfunction

   // clamp to full level, then apply lamp polarity
   function automatic logic [7:0] duty_of(input logic [7:0] level);
      logic [7:0] c;
      c = (level > cfg.full_level) ? cfg.full_level : level;
      return cfg.active_high ? c : 8'd255 - c;
   endfunction

   function automatic void take_beat(input logic op, input logic [3:0] code);
      lamp_beat_type e;
      if (op == OP_TICK) tick_effects();
      else if (code <= MODE_OFF) start_effect(code);
      e.red    = duty_of(lamp.red);
      e.yellow = duty_of(lamp.yellow);
      e.green  = duty_of(lamp.green);
      e.mode   = cur_mode;
      due_lamps.push_back(e);
   endfunction

   // watch all three ports at each edge
   always @(posedge clock) begin
      lamp_beat_type got;
      lamp_beat_type want;
      if (reset) begin
         cfg.active_high     = 1'b0;
         cfg.full_level      = FULL_LEVEL_RST;
         cfg.soft_level      = SOFT_LEVEL_RST;
         cfg.trail_level     = TRAIL_LEVEL_RST;
         cfg.breath_floor    = BREATH_FLOOR_RST;
         cfg.hold_ticks      = SUCCESS_HOLD_RST;
         start_effect(MODE_OFF);
         due_lamps.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ACTIVE_HIGH:  cfg.active_high     = csr_wdata[0];
               CSR_FULL_LEVEL:   cfg.full_level      = csr_wdata[7:0];
               CSR_SOFT_LEVEL:   cfg.soft_level      = csr_wdata[7:0];
               CSR_TRAIL_LEVEL:  cfg.trail_level     = csr_wdata[7:0];
               CSR_BREATH_FLOOR: cfg.breath_floor    = csr_wdata[7:0];
               CSR_SUCCESS_HOLD: cfg.hold_ticks      = csr_wdata[15:0];
               default: ;
            endcase
         end
         // compare the rsp beat before queueing this edge's req beat
         if (rsp_valid && rsp_ready) begin
            got = {rsp_red_duty, rsp_yellow_duty, rsp_green_duty, rsp_mode_now};
            if (due_lamps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected rsp beat r=%0d y=%0d g=%0d mode=%0d",
                           $time, got.red, got.yellow, got.green, got.mode);
            end else begin
               want = due_lamps.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: exp r=%0d y=%0d g=%0d m=%0d got r=%0d y=%0d g=%0d m=%0d",
                              $time, want.red, want.yellow, want.green, want.mode,
                              got.red, got.yellow, got.green, got.mode);
               end
            end
         end
         if (req_valid && req_ready) take_beat(req_opcode, req_mode_code);
      end
      queued = due_lamps.size();
   end

endmodule

// ===== bench/tb_status_light_effect_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_status_light_effect_sequencer_unit - sequencer testbench top
// Drives tick and mode beats through several register settings and pacing
// modes, plus soak runs for the slow busy blink and the soft chase.
// The slse_checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_status_light_effect_sequencer_unit;
   import slse_pkg::*;

   logic                     clock;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic                     req_opcode    = 1'b0;
   logic [3:0]               req_mode_code = 4'd0;
   logic                     rsp_ready     = 1'b0;
   logic                     csr_wr_en     = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index     = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata     = '0;
   logic                     req_ready;
   logic                     rsp_valid;
   logic [7:0]               rsp_red_duty;
   logic [7:0]               rsp_yellow_duty;
   logic [7:0]               rsp_green_duty;
   logic [3:0]               rsp_mode_now;

   int fail_count;
   int pending_count;
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int beats_sent    = 0;
   int mode_cmds     = 0;
   int settings_run  = 0;

   status_light_effect_sequencer_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_mode_code   (req_mode_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_duty    (rsp_red_duty),
      .rsp_yellow_duty (rsp_yellow_duty),
      .rsp_green_duty  (rsp_green_duty),
      .rsp_mode_now    (rsp_mode_now),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   slse_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_mode_code   (req_mode_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_duty    (rsp_red_duty),
      .rsp_yellow_duty (rsp_yellow_duty),
      .rsp_green_duty  (rsp_green_duty),
      .rsp_mode_now    (rsp_mode_now),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

   // rsp side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic set_idling(input int kind);
      case (kind)
         1:       begin req_gap_pct = 62; rsp_stall_pct = 0;  end
         2:       begin req_gap_pct = 0;  rsp_stall_pct = 62; end
         3:       begin req_gap_pct = 38; rsp_stall_pct = 38; end
         default: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
      endcase
   endtask

   // one req beat; returns just after the edge that took it, valid left high
   task automatic send_beat(input logic op, input logic [3:0] code);
      while (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_mode_code <= code;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      beats_sent++;
      if (op == OP_MODE) mode_cmds++;
   endtask

   // drop valid and wait for every predicted rsp beat, plus the pipeline stage
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic ah, input logic [7:0] full, input logic [7:0] soft_lv,
                                input logic [7:0] trail, input logic [7:0] floor_lv,
                                input logic [15:0] hold);
      csr_put(CSR_ACTIVE_HIGH,  {15'd0, ah});
      csr_put(CSR_FULL_LEVEL,   {8'd0, full});
      csr_put(CSR_SOFT_LEVEL,   {8'd0, soft_lv});
      csr_put(CSR_TRAIL_LEVEL,  {8'd0, trail});
      csr_put(CSR_BREATH_FLOOR, {8'd0, floor_lv});
      csr_put(CSR_SUCCESS_HOLD, hold);
      csr_wr_en <= 1'b0;
      settings_run++;
   endtask

   // mostly mode command + tick run, with some stray beats and bad codes
   task automatic random_burst(input int n);
      int         done;
      int         run;
      int         pick;
      logic       op;
      logic [3:0] code;
      done = 0;
      while (done < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            send_beat(OP_MODE, 4'($urandom_range(0, MODE_OFF)));
            pick = $urandom_range(0, 99);
            run  = (pick < 60) ? $urandom_range(1, 20) :
                   (pick < 95) ? $urandom_range(20, 160) : $urandom_range(160, 400);
            repeat (run) send_beat(OP_TICK, 4'($urandom_range(0, 15)));
            done += run + 1;
         end else begin
            op   = 1'($urandom_range(0, 1));
            code = 4'($urandom_range(0, 15));
            send_beat(op, code);
            if (!(op == OP_MODE && code > MODE_OFF)) done++;
         end
      end
   endtask

   task automatic soak(input logic [3:0] m, input int ticks);
      send_beat(OP_MODE, m);
      repeat (ticks) send_beat(OP_TICK, 4'($urandom_range(0, 15)));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every mode code including the ignored ones, from reset settings
      for (int code = 0; code < 16; code++) begin
         send_beat(OP_MODE, 4'(code));
         if (code != 6 && code != 7) send_beat(OP_TICK, 4'(15 - code));
      end
      settle();

      // random traffic under several settings and pacing modes
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: load_settings(1'b0, FULL_LEVEL_RST, SOFT_LEVEL_RST, TRAIL_LEVEL_RST,
                             BREATH_FLOOR_RST, 16'd90);
            1: load_settings(1'b1, 8'd255, 8'd255, 8'd0, 8'd0, 16'd0);
            2: load_settings(1'b0, 8'd0, 8'd255, 8'd255, 8'd255, 16'd1);
            3: load_settings(1'b1, 8'd20, 8'd30, 8'd7, 8'd15, 16'd37);
            4: load_settings(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 16'($urandom_range(0, 400)));
            default: load_settings(1'b1, 8'd9, 8'd5, 8'd200, 8'd9, 16'hFFFF);
         endcase
         set_idling(p % 4);
         random_burst(50);
         settle();
      end

      // soak: the slow busy blink and the soft chase past their frame intervals
      set_idling(0);
      load_settings(1'b0, 8'd200, 8'd120, 8'd40, 8'd6, 16'd300);
      soak(MODE_BUSY, 560);
      soak(MODE_AI, 250);
      settle();

      $display("covered %0d req beats (%0d mode commands) over %0d register settings,",
               beats_sent, mode_cmds, settings_run);
      $display("four pacing modes, all mode codes and soaks of the slow blink and chase");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
